// ----- src/cbm_pkg.sv -----
// Package for the chunk buffer manager: widths, command and grant codes,
// register indexes and the payload structs. No dependencies.
`timescale 1ns / 1ps
package cbm_pkg;
    localparam int MAX_CHUNKS = 16;
    localparam int ID_W  = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

    localparam logic [1:0] CMD_REQUEST    = 2'd0;
    localparam logic [1:0] CMD_GET_NEXT   = 2'd1;
    localparam logic [1:0] CMD_WRITE_DONE = 2'd2;
    localparam logic [1:0] CMD_RELEASE    = 2'd3;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_REUSED  = 2'd1;
    localparam logic [1:0] KIND_CARVED  = 2'd2;
    localparam logic [1:0] KIND_RECLAIM = 2'd3;

    localparam logic REG_TOTAL_BYTES = 1'b0;
    localparam logic REG_MAX_CHUNK   = 1'b1;
    localparam logic [31:0] TOTAL_BYTES_RESET = 32'd1048576;

    typedef struct packed {
        logic [1:0]      command;
        logic [31:0]     request_bytes;
        logic [ID_W-1:0] chunk_id;
        logic            write_valid;
        logic            was_served;
    } cmd_word_t;

    typedef struct packed {
        logic [ID_W-1:0]  result_chunk;
        logic             result_valid;
        logic [1:0]       grant_kind;
        logic             buffer_emptied;
        logic [CNT_W-1:0] waiting_count;
        logic [CNT_W-1:0] empty_count;
        logic [31:0]      allocated_bytes;
    } res_word_t;
endpackage

// ----- src/cbm_if.sv -----
// Valid/ready channels carrying one command word or one result word.
// Depends on cbm_pkg for the payload types.
`timescale 1ns / 1ps
interface cbm_cmd_if;
    import cbm_pkg::*;
    logic      valid;
    logic      ready;
    cmd_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cbm_res_if;
    import cbm_pkg::*;
    logic      valid;
    logic      ready;
    res_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/chunk_buffer_manager.sv -----
// Chunk buffer manager top level: list sequencer over register-file lists.
// Depends on cbm_pkg and the channel interfaces in cbm_if.sv.
`timescale 1ns / 1ps
// One command word is taken at a time. A command walks the lists one entry
// a cycle through a single shared compare/shift step. A request scans the
// empty list, makes the carve check, scans the serve queue, then shifts the
// list to close the gap; both lists together never hold more than MAX_CHUNKS
// entries. Get next shifts the serve queue to drop its head, and write done
// or release runs a membership sweep over both lists, then the closing S_DONE
// state; an unserved release opens a slot at the queue head before S_DONE.
// The result word sits in an output register; the block takes no new command
// until that word has been taken. Configuration writes land on cfg_we; write
// them only while no command is in flight.
module chunk_buffer_manager
    import cbm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    cbm_cmd_if.sink      cmd,
    cbm_res_if.source    res
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCANE = 3'd1; // scan empty list
    localparam logic [2:0] S_CARVE = 3'd2;
    localparam logic [2:0] S_SCANS = 3'd3; // scan serve queue
    localparam logic [2:0] S_SHIFT = 3'd4; // close gap at pos
    localparam logic [2:0] S_INS   = 3'd5; // open slot at head
    localparam logic [2:0] S_MEMB  = 3'd6; // membership sweep
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [31:0] total_reg, maxc_reg;
    logic [31:0] cap_reg [MAX_CHUNKS];
    logic [ID_W-1:0] elist_reg [MAX_CHUNKS];
    logic [ID_W-1:0] slist_reg [MAX_CHUNKS];
    logic [CNT_W-1:0] created_reg, elen_reg, slen_reg;
    logic [31:0] carved_reg;
    logic [2:0] state_reg;
    logic [CNT_W-1:0] pos_reg;
    logic which_reg; // list being shifted: 0 empty, 1 serve
    logic found_reg;
    cmd_word_t cw_reg;
    res_word_t out_reg;
    logic out_valid_reg;

    // shared unit: one list entry, one capacity compare
    logic [ID_W-1:0] entry;
    logic fits, hit;
    logic [31:0] space, limit;
    res_word_t head_word;
    assign entry = which_reg ? slist_reg[pos_reg[ID_W-1:0]]
                             : elist_reg[pos_reg[ID_W-1:0]];
    assign fits  = cap_reg[entry] >= cw_reg.request_bytes;
    assign hit   = entry == cw_reg.chunk_id;
    assign space = (carved_reg > total_reg) ? 32'd0 : total_reg - carved_reg;
    assign limit = (maxc_reg == 32'd0) ? total_reg : maxc_reg;

    // result word for get next: the queue head, everything else cleared
    always_comb
    begin
        head_word = '0;
        head_word.result_chunk = slist_reg[0];
        head_word.result_valid = 1'b1;
    end

    assign cmd.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= TOTAL_BYTES_RESET;
            maxc_reg      <= '0;
            created_reg   <= '0;
            carved_reg    <= '0;
            elen_reg      <= '0;
            slen_reg      <= '0;
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            which_reg     <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_TOTAL_BYTES) total_reg <= cfg_data;
                else maxc_reg <= cfg_data;
            end
            if (res.valid && res.ready) out_valid_reg <= 1'b0;
            case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && cmd.ready)
                begin
                    cw_reg <= cmd.data;
                    pos_reg <= '0;
                    found_reg <= 1'b0;
                    case (cmd.data.command)
                    CMD_REQUEST:
                    begin
                        out_reg <= '0;
                        which_reg <= 1'b0;
                        state_reg <= S_SCANE;
                    end
                    CMD_GET_NEXT:
                    begin
                        if (slen_reg != '0)
                        begin
                            out_reg <= head_word;
                            which_reg <= 1'b1;
                            state_reg <= S_SHIFT;
                        end
                        else
                        begin
                            out_reg <= '0;
                            state_reg <= S_DONE;
                        end
                    end
                    default:
                    begin
                        // write done / release: unknown chunk is dropped
                        out_reg <= '0;
                        if ({1'b0, cmd.data.chunk_id} < created_reg)
                        begin
                            which_reg <= 1'b0;
                            state_reg <= S_MEMB;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                    endcase
                end
            end
            S_SCANE:
            begin
                if (pos_reg >= elen_reg)
                    state_reg <= S_CARVE;
                else if (fits)
                begin
                    out_reg.result_chunk <= entry;
                    out_reg.result_valid <= 1'b1;
                    out_reg.grant_kind <= KIND_REUSED;
                    state_reg <= S_SHIFT;
                end
                else
                    pos_reg <= pos_reg + 1'b1;
            end
            S_CARVE:
            begin
                if (cw_reg.request_bytes <= space && cw_reg.request_bytes <= limit
                    && created_reg < CNT_W'(MAX_CHUNKS))
                begin
                    cap_reg[created_reg[ID_W-1:0]] <= cw_reg.request_bytes;
                    out_reg.result_chunk <= created_reg[ID_W-1:0];
                    out_reg.result_valid <= 1'b1;
                    out_reg.grant_kind <= KIND_CARVED;
                    created_reg <= created_reg + 1'b1;
                    carved_reg <= carved_reg + cw_reg.request_bytes;
                    state_reg <= S_DONE;
                end
                else
                begin
                    which_reg <= 1'b1;
                    pos_reg <= '0;
                    state_reg <= S_SCANS;
                end
            end
            S_SCANS:
            begin
                if (pos_reg >= slen_reg)
                    state_reg <= S_DONE;
                else if (fits)
                begin
                    out_reg.result_chunk <= entry;
                    out_reg.result_valid <= 1'b1;
                    out_reg.grant_kind <= KIND_RECLAIM;
                    state_reg <= S_SHIFT;
                end
                else
                    pos_reg <= pos_reg + 1'b1;
            end
            S_SHIFT:
            begin
                // advance entries down one slot, then drop the tail
                if (pos_reg + 1'b1 < (which_reg ? slen_reg : elen_reg))
                begin
                    if (which_reg)
                        slist_reg[pos_reg[ID_W-1:0]] <= slist_reg[pos_reg[ID_W-1:0] + 1'b1];
                    else
                        elist_reg[pos_reg[ID_W-1:0]] <= elist_reg[pos_reg[ID_W-1:0] + 1'b1];
                    pos_reg <= pos_reg + 1'b1;
                end
                else
                begin
                    if (which_reg) slen_reg <= slen_reg - 1'b1;
                    else elen_reg <= elen_reg - 1'b1;
                    state_reg <= S_DONE;
                end
            end
            S_MEMB:
            begin
                if (pos_reg < (which_reg ? slen_reg : elen_reg) && hit)
                    found_reg <= 1'b1;
                if (pos_reg + 1'b1 < CNT_W'(MAX_CHUNKS))
                    pos_reg <= pos_reg + 1'b1;
                else if (!which_reg)
                begin
                    which_reg <= 1'b1;
                    pos_reg <= '0;
                end
                else if (found_reg || (pos_reg < slen_reg && hit))
                    state_reg <= S_DONE;
                else if (cw_reg.command == CMD_WRITE_DONE)
                begin
                    if (cw_reg.write_valid)
                    begin
                        slist_reg[slen_reg[ID_W-1:0]] <= cw_reg.chunk_id;
                        slen_reg <= slen_reg + 1'b1;
                    end
                    else
                    begin
                        elist_reg[elen_reg[ID_W-1:0]] <= cw_reg.chunk_id;
                        elen_reg <= elen_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                else if (cw_reg.was_served)
                begin
                    out_reg.buffer_emptied <= (slen_reg == '0);
                    elist_reg[elen_reg[ID_W-1:0]] <= cw_reg.chunk_id;
                    elen_reg <= elen_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                else
                begin
                    pos_reg <= slen_reg;
                    state_reg <= S_INS;
                end
            end
            S_INS:
            begin
                // hold the queue order: move each entry up one, head last
                if (pos_reg != '0)
                begin
                    slist_reg[pos_reg[ID_W-1:0]] <= slist_reg[pos_reg[ID_W-1:0] - 1'b1];
                    pos_reg <= pos_reg - 1'b1;
                end
                else
                begin
                    slist_reg[0] <= cw_reg.chunk_id;
                    slen_reg <= slen_reg + 1'b1;
                    state_reg <= S_DONE;
                end
            end
            S_DONE:
            begin
                out_reg.waiting_count <= slen_reg;
                out_reg.empty_count <= elen_reg;
                out_reg.allocated_bytes <= carved_reg;
                out_valid_reg <= 1'b1;
                state_reg <= S_IDLE;
            end
            default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        (slen_reg + elen_reg) <= created_reg) else $error("list lengths exceed chunks");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd.ready) else $error("ready while busy");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.data.result_valid == (res.data.grant_kind != KIND_NONE)
                       || res.data.grant_kind == KIND_NONE)) else $error("grant kind");
`endif
endmodule

// ----- verif/cbm_checker.sv -----
// Scoreboard for the chunk buffer manager: mirrors pool state, predicts the
// result word for each accepted command word and compares. Depends on cbm_pkg, cbm_if.sv.
`timescale 1ns / 1ps
module cbm_checker
    import cbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    cbm_cmd_if          cmd,
    cbm_res_if          res,
    output int          fail_count,
    output int          pending,
    output int          words_checked,
    output int          reused_seen,
    output int          carved_seen,
    output int          reclaimed_seen,
    output int          emptied_seen
);
    logic [31:0]     pool_bytes;
    logic [31:0]     chunk_limit;
    logic [31:0]     capacity [MAX_CHUNKS];
    logic [4:0]      created;
    logic [31:0]     carved;
    logic [ID_W-1:0] empty_ids [MAX_CHUNKS];
    logic [ID_W-1:0] serve_ids [MAX_CHUNKS];
    int              empty_len;
    int              serve_len;
    res_word_t       expected_words [$];

    assign pending = expected_words.size();

    task automatic apply_command(input cmd_word_t w, output res_word_t r);
        logic [31:0] room;
        logic [31:0] cap_limit;
        bit          listed;
        int          i;
        int          j;
        r = '0;
        if (w.command == CMD_REQUEST) begin
            for (i = 0; i < empty_len && r.grant_kind == KIND_NONE; i++) begin
                if (capacity[empty_ids[i]] >= w.request_bytes) begin
                    r.result_chunk = empty_ids[i];
                    r.grant_kind = KIND_REUSED;
                    for (j = i; j + 1 < empty_len; j++)
                        empty_ids[j] = empty_ids[j + 1];
                    empty_len--;
                end
            end
            if (r.grant_kind == KIND_NONE) begin
                room = (carved > pool_bytes) ? 32'd0 : pool_bytes - carved;
                cap_limit = (chunk_limit == 0) ? pool_bytes : chunk_limit;
                if (w.request_bytes <= room && w.request_bytes <= cap_limit
                    && created < MAX_CHUNKS) begin
                    capacity[created[ID_W-1:0]] = w.request_bytes;
                    r.result_chunk = created[ID_W-1:0];
                    r.grant_kind = KIND_CARVED;
                    created = created + 5'd1;
                    carved = carved + w.request_bytes;
                end
            end
            for (i = 0; i < serve_len && r.grant_kind == KIND_NONE; i++) begin
                if (capacity[serve_ids[i]] >= w.request_bytes) begin
                    r.result_chunk = serve_ids[i];
                    r.grant_kind = KIND_RECLAIM;
                    for (j = i; j + 1 < serve_len; j++)
                        serve_ids[j] = serve_ids[j + 1];
                    serve_len--;
                end
            end
            r.result_valid = (r.grant_kind != KIND_NONE);
        end
        else if (w.command == CMD_GET_NEXT) begin
            if (serve_len > 0) begin
                r.result_chunk = serve_ids[0];
                r.result_valid = 1'b1;
                for (j = 0; j + 1 < serve_len; j++)
                    serve_ids[j] = serve_ids[j + 1];
                serve_len--;
            end
        end
        else if (w.chunk_id < created) begin
            listed = 0;
            for (i = 0; i < empty_len; i++)
                if (empty_ids[i] == w.chunk_id) listed = 1;
            for (i = 0; i < serve_len; i++)
                if (serve_ids[i] == w.chunk_id) listed = 1;
            if (!listed) begin
                if (w.command == CMD_WRITE_DONE) begin
                    if (w.write_valid) serve_ids[serve_len++] = w.chunk_id;
                    else               empty_ids[empty_len++] = w.chunk_id;
                end
                else if (!w.was_served) begin
                    for (i = serve_len; i > 0; i--)
                        serve_ids[i] = serve_ids[i - 1];
                    serve_ids[0] = w.chunk_id;
                    serve_len++;
                end
                else begin
                    r.buffer_emptied = (serve_len == 0);
                    empty_ids[empty_len++] = w.chunk_id;
                end
            end
        end
        r.waiting_count = serve_len[CNT_W-1:0];
        r.empty_count = empty_len[CNT_W-1:0];
        r.allocated_bytes = carved;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_word_t want;
        res_word_t got;
        if (!rst_n)
        begin
            pool_bytes <= TOTAL_BYTES_RESET;
            chunk_limit <= '0;
            created <= '0;
            carved <= '0;
            empty_len <= 0;
            serve_len <= 0;
            fail_count <= 0;
            words_checked <= 0;
            reused_seen <= 0;
            carved_seen <= 0;
            reclaimed_seen <= 0;
            emptied_seen <= 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_TOTAL_BYTES) pool_bytes = cfg_data;
                else                              chunk_limit = cfg_data;
            end
            if (cmd.valid && cmd.ready)
            begin
                apply_command(cmd.data, want);
                expected_words = {expected_words, want};
            end
            if (res.valid && res.ready)
            begin
                got = res.data;
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected: %p", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    words_checked <= words_checked + 1;
                    if (got.result_valid && got.grant_kind == KIND_REUSED)
                        reused_seen <= reused_seen + 1;
                    if (got.result_valid && got.grant_kind == KIND_CARVED)
                        carved_seen <= carved_seen + 1;
                    if (got.result_valid && got.grant_kind == KIND_RECLAIM)
                        reclaimed_seen <= reclaimed_seen + 1;
                    if (got.buffer_emptied) emptied_seen <= emptied_seen + 1;
                    if (got !== want)
                    begin
                        fail_count <= fail_count + 1;
                        if (got.result_chunk !== want.result_chunk)
                            $error("result_chunk: expected %0d, got %0d",
                                   want.result_chunk, got.result_chunk);
                        if (got.result_valid !== want.result_valid)
                            $error("result_valid: expected %0d, got %0d",
                                   want.result_valid, got.result_valid);
                        if (got.grant_kind !== want.grant_kind)
                            $error("grant_kind: expected %0d, got %0d",
                                   want.grant_kind, got.grant_kind);
                        if (got.buffer_emptied !== want.buffer_emptied)
                            $error("buffer_emptied: expected %0d, got %0d",
                                   want.buffer_emptied, got.buffer_emptied);
                        if (got.waiting_count !== want.waiting_count)
                            $error("waiting_count: expected %0d, got %0d",
                                   want.waiting_count, got.waiting_count);
                        if (got.empty_count !== want.empty_count)
                            $error("empty_count: expected %0d, got %0d",
                                   want.empty_count, got.empty_count);
                        if (got.allocated_bytes !== want.allocated_bytes)
                            $error("allocated_bytes: expected %0h, got %0h",
                                   want.allocated_bytes, got.allocated_bytes);
                    end
                end
            end
        end
    end
endmodule

// ----- verif/testbench.sv -----
// Testbench top for the chunk buffer manager: clock, reset, command stimulus,
// result back-pressure, register settings and verdict. Depends on cbm_pkg, cbm_if.sv, cbm_checker.
`timescale 1ns / 1ps
module testbench;
    import cbm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    // quiet margin after the last result before a register write
    localparam int SETTLE = 2 * MAX_CHUNKS + 12;
    localparam int PHASE_WORDS = 350;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          words_checked;
    int          reused_seen;
    int          carved_seen;
    int          reclaimed_seen;
    int          emptied_seen;
    int          cycles;
    int          send_idle;
    int          recv_stall;
    int          hold_off;

    cbm_cmd_if cmd_ch ();
    cbm_res_if res_ch ();

    chunk_buffer_manager dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    cbm_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd_ch),
        .res            (res_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .words_checked  (words_checked),
        .reused_seen    (reused_seen),
        .carved_seen    (carved_seen),
        .reclaimed_seen (reclaimed_seen),
        .emptied_seen   (emptied_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: abandon the run if it hangs.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Receiver: stall at random, or hold off completely while hold_off counts down.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_off--;
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Offer one word, idling first at the current rate; return at the
    // edge where it was taken. Ready is read at the falling edge to stay clear
    // of the rising-edge updates.
    task automatic send_word(input cmd_word_t w);
        if ($urandom_range(0, 99) < send_idle)
        begin
            cmd_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
        end
        cmd_ch.data <= w;
        cmd_ch.valid <= 1'b1;
        do @(negedge clk); while (!cmd_ch.ready);
        @(posedge clk);
    endtask

    task automatic send_cmd(input logic [1:0] op, input logic [31:0] bytes,
                            input int id, input bit wv, input bit served);
        cmd_word_t w;
        w.command = op;
        w.request_bytes = bytes;
        w.chunk_id = id[ID_W-1:0];
        w.write_valid = wv;
        w.was_served = served;
        send_word(w);
    endtask

    // Drop valid and wait until every result has come back.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Write both registers while the block is idle.
    task automatic set_pool(input logic [31:0] total, input logic [31:0] max_chunk);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_TOTAL_BYTES;
        cfg_data <= total;
        @(posedge clk);
        cfg_index <= REG_MAX_CHUNK;
        cfg_data <= max_chunk;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return $urandom_range(0, 64);
        if (roll < 80) return $urandom_range(0, 4096);
        if (roll < 90) return $urandom;
        return roll[0] ? 32'hFFFF_FFFF : 32'd0;
    endfunction

    // Mostly well-formed traffic over the sixteen ids, with full random noise.
    task automatic send_random();
        int roll;
        logic [1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < 35)      op = CMD_REQUEST;
        else if (roll < 55) op = CMD_GET_NEXT;
        else if (roll < 80) op = CMD_WRITE_DONE;
        else                op = CMD_RELEASE;
        send_cmd(op, pick_size(), $urandom_range(0, MAX_CHUNKS - 1),
                 $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    task automatic random_words(input int count);
        repeat (count) send_random();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TOTAL_BYTES;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening on the reset pool settings.
        send_cmd(CMD_GET_NEXT, 0, 0, 0, 0);              // empty serve queue
        send_cmd(CMD_WRITE_DONE, 0, 9, 1, 0);            // unknown chunk
        send_cmd(CMD_RELEASE, 0, 15, 0, 1);              // unknown chunk
        send_cmd(CMD_REQUEST, 32'd0, 0, 0, 0);           // carve a zero-size chunk
        send_cmd(CMD_REQUEST, 32'hFFFF_FFFF, 0, 0, 0);   // nothing fits
        send_cmd(CMD_REQUEST, 32'd100, 0, 0, 0);
        send_cmd(CMD_WRITE_DONE, 0, 0, 1, 0);
        send_cmd(CMD_WRITE_DONE, 0, 0, 0, 0);            // already queued
        send_cmd(CMD_GET_NEXT, 0, 0, 0, 0);
        send_cmd(CMD_RELEASE, 0, 0, 0, 1);               // served, queue empty
        send_cmd(CMD_RELEASE, 0, 0, 1, 1);               // already on empty list
        send_cmd(CMD_REQUEST, 32'd50, 0, 0, 0);          // zero chunk too small: carve
        send_cmd(CMD_WRITE_DONE, 0, 1, 0, 0);
        send_cmd(CMD_REQUEST, 32'd0, 0, 0, 0);           // reuse earliest empty
        send_cmd(CMD_REQUEST, 32'd100, 0, 0, 0);         // reuse the larger one
        send_cmd(CMD_WRITE_DONE, 0, 2, 1, 0);
        send_cmd(CMD_RELEASE, 0, 1, 0, 0);               // unserved: back to the head
        send_cmd(CMD_RELEASE, 0, 0, 1, 1);               // served, queue not empty
        send_cmd(CMD_REQUEST, 32'd1048576, 0, 0, 0);     // more than the room left
        send_cmd(CMD_REQUEST, 32'd1048426, 0, 0, 0);     // fills the pool exactly
        send_cmd(CMD_REQUEST, 32'd60, 0, 0, 0);          // pool full: reclaim
        send_cmd(CMD_GET_NEXT, 0, 0, 0, 0);
        send_cmd(CMD_GET_NEXT, 0, 0, 0, 0);
        random_words(PHASE_WORDS - 23);

        // Widest pool and limit; sender mostly idle.
        set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_idle = 84;
        random_words(PHASE_WORDS);

        // Tiny pool: everything carved so far now overcommits it.
        set_pool(32'd1, 32'd1);
        send_idle = 0;
        recv_stall = 84;
        random_words(PHASE_WORDS / 2);
        // Hold the receiver off for a long stretch while words keep coming.
        hold_off = 400;
        random_words(PHASE_WORDS / 2);

        set_pool(32'd4096, 32'd0);
        send_idle = 32;
        recv_stall = 32;
        random_words(PHASE_WORDS / 2);
        // Pause the sender until every result is back, then carry on.
        drain();
        random_words(PHASE_WORDS / 2);

        set_pool(32'd1048576, 32'd2048);
        send_idle = 0;
        recv_stall = 0;
        random_words(PHASE_WORDS);

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("checked %0d result words: %0d reused, %0d carved, %0d reclaimed grants",
                 words_checked, reused_seen, carved_seen, reclaimed_seen);
        $display("%0d served releases emptied the queue; %0d cycles",
                 emptied_seen, cycles);
        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/cbm_pkg.sv
src/cbm_if.sv
src/chunk_buffer_manager.sv
verif/cbm_checker.sv
verif/testbench.sv
